// ===== design/json_string_unescape_decoder_top_defines.svh =====
// Assertion macros shared by the checker of the JSON string unescape decoder.
// No dependencies; included by the checker file only.
`ifndef JSON_STRING_UNESCAPE_DECODER_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JSU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jsu check failed");

// Next-cycle implication, checked outside reset.
`define JSU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jsu check failed");

// Condition that must hold in the cycle after reset is applied.
`define JSU_ASSERT_RST(label, cons) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("jsu check failed");

`endif

// ===== design/jsu_pkg.sv =====
// Shared types, codes and character tables of the JSON string unescape decoder.
// No dependencies; used by every module of the block.
package jsu_pkg;

  // Error codes carried on the result channel.
  localparam logic [3:0] ErrNone        = 4'd0;
  localparam logic [3:0] ErrBadHex      = 4'd1;
  localparam logic [3:0] ErrUnknownEsc  = 4'd2;
  localparam logic [3:0] ErrUntermEsc   = 4'd3;
  localparam logic [3:0] ErrBadSurr     = 4'd4;
  localparam logic [3:0] ErrBadLead     = 4'd5;
  localparam logic [3:0] ErrBadCont     = 4'd6;
  localparam logic [3:0] ErrUnprintable = 4'd7;
  localparam logic [3:0] ErrUntermUtf8  = 4'd8;

  // Characters with a role in the syntax.
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChU         = 8'h75;

  // Configuration port.
  localparam int unsigned CfgAddrW = 3;
  localparam logic        RegStrict = 1'b0;

  // Burst queue between parser and serializer.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // All results caused by one input byte.
  typedef struct packed {
    logic [3:0][7:0] data;       // decoded bytes, entry 0 first
    logic [1:0]      last_idx;   // index of the final result
    logic            byte_valid; // results carry bytes
    logic [3:0]      err;        // error code of an error result
    logic            str_end;    // burst closes the string
  } jsu_burst_t;

  // {bad, value}: bad is set when b is no hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b0, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      r = {1'b0, b[3:0] + 4'd9};
    return r;
  endfunction

  // {hit, byte} for the single-character escapes.
  function automatic logic [8:0] simple_escape(input logic [7:0] b);
    logic [8:0] r;
    r = 9'h000;
    case (b)
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0c};
      8'h6e:   r = {1'b1, 8'h0a};
      8'h72:   r = {1'b1, 8'h0d};
      8'h74:   r = {1'b1, 8'h09};
      8'h5c:   r = {1'b1, 8'h5c};
      8'h2f:   r = {1'b1, 8'h2f};
      8'h22:   r = {1'b1, 8'h22};
      default: r = 9'h000;
    endcase
    return r;
  endfunction

  // Sequence length of a byte at or above 80h; zero when it is no lead.
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] r;
    if (b < 8'hc0)      r = 3'd0;
    else if (b < 8'he0) r = 3'd2;
    else if (b < 8'hf0) r = 3'd3;
    else if (b < 8'hf8) r = 3'd4;
    else if (b < 8'hfc) r = 3'd5;
    else if (b < 8'hfe) r = 3'd6;
    else                r = 3'd0;
    return r;
  endfunction

endpackage

// ===== design/json_string_unescape_decoder_top.sv =====
// JSON string unescape decoder, top level. Takes one string-body byte per
// transfer and returns decoded UTF-8 bytes, error codes and end markers.
// Depends on jsu_pkg, jsu_front, jsu_fifo and jsu_back.
//
// Users: an input byte is taken whenever the burst queue has room, so bytes
// stream in at one per clock. Each byte causes zero to four results (a
// surrogate pair decodes into four), which leave through the output queue
// interface at one result per cycle while the receiver keeps popping; the
// serializer in the back part sets the output rate, and a four-entry burst
// queue lets the input side keep going while a long burst drains. A string
// whose first error is seen reports a single error result, drops the rest
// of its bytes, and still closes with a result that has string_end set. The
// strict_printable register (address 0, bit 0) must only be written while no
// string data is in flight; no clearing pass is needed after reset.
module json_string_unescape_decoder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel.
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  in_byte,
  input  logic                        in_last,
  // Result channel.
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  out_byte,
  output logic                        out_byte_valid,
  output logic [3:0]                  out_error_code,
  output logic                        out_string_end,
  output logic                        out_run_last,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jsu_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic                strict_r;
  logic                accept;
  logic                burst_push;
  jsu_pkg::jsu_burst_t burst;
  jsu_pkg::jsu_burst_t head;
  logic                q_full, q_empty, q_pop;

  // Configuration: one register, written on the access phase of a transfer.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == jsu_pkg::RegStrict) ? {31'd0, strict_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == jsu_pkg::RegStrict) begin
      strict_r <= pwdata[0];
    end
  end

  // Input is held off only while the burst queue is full, which keeps the
  // parser state in step with the bursts already queued.
  assign full   = q_full;
  assign accept = push && !q_full;

  jsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .strict     (strict_r),
    .accept     (accept),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .burst_push (burst_push),
    .burst      (burst)
  );

  jsu_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (burst_push),
    .wdata (burst),
    .pop   (q_pop),
    .rdata (head),
    .full  (q_full),
    .empty (q_empty)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_error_code (out_error_code),
    .out_string_end (out_string_end),
    .out_run_last   (out_run_last)
  );

endmodule

// ===== design/jsu_front.sv =====
// Parser of the JSON string unescape decoder: tracks escapes, hex and UTF-8 state
// and makes at most one burst of results per accepted byte. Depends on jsu_pkg.
module jsu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               strict,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output logic               burst_push,
  output jsu_pkg::jsu_burst_t burst
);

  typedef enum logic [2:0] {
    M_TEXT, M_ESC, M_HEX, M_PAIR_BS, M_PAIR_U, M_PAIR_HEX
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] hs_r, hs_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic        drop_r, drop_nxt;

  logic [3:0][7:0] bytes;
  logic [2:0]      n;
  logic [3:0]      err;
  logic [8:0]      esc;
  logic [4:0]      hex;
  logic [15:0]     new_acc;
  logic [2:0]      len;
  logic [20:0]     cp;
  logic            emit;

  assign esc     = jsu_pkg::simple_escape(in_byte);
  assign hex     = jsu_pkg::hex_value(in_byte);
  assign new_acc = {acc_r[11:0], hex[3:0]};
  assign len     = jsu_pkg::lead_length(in_byte);
  assign cp      = 21'h10000 + {1'b0, hs_r[9:0], new_acc[9:0]};

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    hs_nxt   = hs_r;
    rem_nxt  = rem_r;
    drop_nxt = drop_r;
    bytes    = '0;
    n        = 3'd0;
    err      = jsu_pkg::ErrNone;
    emit     = 1'b0;
    burst    = '0;

    if (drop_r) begin
      // The string already failed; only its final byte yields an end marker.
      if (in_last) begin
        emit          = 1'b1;
        burst.str_end = 1'b1;
        drop_nxt      = 1'b0;
      end
    end else begin
      unique case (mode_r)
        M_ESC: begin
          if (esc[8]) begin
            bytes[0] = esc[7:0];
            n        = 3'd1;
            mode_nxt = M_TEXT;
          end else if (in_byte == jsu_pkg::ChU) begin
            mode_nxt = M_HEX;
            acc_nxt  = '0;
            cnt_nxt  = '0;
          end else begin
            err = jsu_pkg::ErrUnknownEsc;
          end
        end
        M_HEX, M_PAIR_HEX: begin
          if (in_last && cnt_r != 2'd3) begin
            err = (mode_r == M_HEX) ? jsu_pkg::ErrUntermEsc : jsu_pkg::ErrBadSurr;
          end else if (hex[4]) begin
            err = jsu_pkg::ErrBadHex;
          end else if (cnt_r != 2'd3) begin
            acc_nxt = new_acc;
            cnt_nxt = cnt_r + 2'd1;
          end else begin
            acc_nxt = '0;
            cnt_nxt = '0;
            if (mode_r == M_HEX) begin
              if (new_acc < 16'hd800 || new_acc > 16'hdfff) begin
                mode_nxt = M_TEXT;
                if (new_acc < 16'h0080) begin
                  bytes[0] = new_acc[7:0];
                  n        = 3'd1;
                end else if (new_acc < 16'h0800) begin
                  bytes[0] = {3'b110, new_acc[10:6]};
                  bytes[1] = {2'b10, new_acc[5:0]};
                  n        = 3'd2;
                end else begin
                  bytes[0] = {4'b1110, new_acc[15:12]};
                  bytes[1] = {2'b10, new_acc[11:6]};
                  bytes[2] = {2'b10, new_acc[5:0]};
                  n        = 3'd3;
                end
              end else begin
                hs_nxt   = new_acc;
                mode_nxt = M_PAIR_BS;
              end
            end else if (hs_r[15:10] != 6'b110110 || new_acc[15:10] != 6'b110111) begin
              err = jsu_pkg::ErrBadSurr;
            end else begin
              bytes[0] = {5'b11110, cp[20:18]};
              bytes[1] = {2'b10, cp[17:12]};
              bytes[2] = {2'b10, cp[11:6]};
              bytes[3] = {2'b10, cp[5:0]};
              n        = 3'd4;
              mode_nxt = M_TEXT;
            end
          end
        end
        M_PAIR_BS: begin
          if (in_byte == jsu_pkg::ChBackslash) mode_nxt = M_PAIR_U;
          else err = jsu_pkg::ErrBadSurr;
        end
        M_PAIR_U: begin
          if (in_byte == jsu_pkg::ChU) begin
            mode_nxt = M_PAIR_HEX;
            acc_nxt  = '0;
            cnt_nxt  = '0;
          end else begin
            err = jsu_pkg::ErrBadSurr;
          end
        end
        default: begin
          mode_nxt = M_TEXT;
          if (rem_r != 3'd0) begin
            if (in_byte[7:6] == 2'b10) begin
              rem_nxt  = rem_r - 3'd1;
              bytes[0] = in_byte;
              n        = 3'd1;
            end else begin
              err = jsu_pkg::ErrBadCont;
            end
          end else if (in_byte == jsu_pkg::ChBackslash) begin
            mode_nxt = M_ESC;
          end else if (!in_byte[7]) begin
            if (strict && (in_byte < 8'h20 || in_byte == 8'h7f)) begin
              err = jsu_pkg::ErrUnprintable;
            end else begin
              bytes[0] = in_byte;
              n        = 3'd1;
            end
          end else if (len == 3'd0) begin
            err = jsu_pkg::ErrBadLead;
          end else begin
            rem_nxt  = len - 3'd1;
            bytes[0] = in_byte;
            n        = 3'd1;
          end
        end
      endcase

      // A string may not end inside an escape or a multi-byte sequence.
      if (err == jsu_pkg::ErrNone && in_last) begin
        if (mode_nxt == M_ESC || mode_nxt == M_HEX) err = jsu_pkg::ErrUntermEsc;
        else if (mode_nxt != M_TEXT) err = jsu_pkg::ErrBadSurr;
        else if (rem_nxt != 3'd0) err = jsu_pkg::ErrUntermUtf8;
      end

      if (err != jsu_pkg::ErrNone) begin
        emit          = 1'b1;
        burst.err     = err;
        burst.str_end = in_last;
        drop_nxt      = !in_last;
      end else if (n != 3'd0) begin
        emit             = 1'b1;
        burst.data       = bytes;
        burst.last_idx   = 2'(n - 3'd1);
        burst.byte_valid = 1'b1;
        burst.str_end    = in_last;
      end else if (in_last) begin
        emit          = 1'b1;
        burst.str_end = 1'b1;
      end

      if (err != jsu_pkg::ErrNone || in_last) begin
        mode_nxt = M_TEXT;
        acc_nxt  = '0;
        cnt_nxt  = '0;
        hs_nxt   = '0;
        rem_nxt  = '0;
      end
    end
  end

  assign burst_push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_TEXT;
      acc_r  <= '0;
      cnt_r  <= '0;
      hs_r   <= '0;
      rem_r  <= '0;
      drop_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      hs_r   <= hs_nxt;
      rem_r  <= rem_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

// ===== design/jsu_fifo.sv =====
// Short queue of result bursts between the parser and the serializer.
// Depends on jsu_pkg for the burst type and depth.
module jsu_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  jsu_pkg::jsu_burst_t wdata,
  input  logic                pop,
  output jsu_pkg::jsu_burst_t rdata,
  output logic                full,
  output logic                empty
);

  jsu_pkg::jsu_burst_t              mem_r [jsu_pkg::QDepth];
  logic [jsu_pkg::QPtrW-1:0]        wptr_r, rptr_r;
  logic [jsu_pkg::QCntW-1:0]        cnt_r;

  assign full  = (cnt_r == jsu_pkg::QCntW'(jsu_pkg::QDepth));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== design/jsu_back.sv =====
// Serializer of the JSON string unescape decoder: walks each queued burst one
// result per cycle into the output register as pops allow. Depends on jsu_pkg.
module jsu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  jsu_pkg::jsu_burst_t head,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output logic [7:0]          out_byte,
  output logic                out_byte_valid,
  output logic [3:0]          out_error_code,
  output logic                out_string_end,
  output logic                out_run_last
);

  logic       valid_r;
  logic [1:0] idx_r;
  logic       load;
  logic       fin;

  assign load  = !q_empty && (!valid_r || pop);
  assign fin   = (idx_r == head.last_idx);
  assign q_pop = load && fin;
  assign empty = !valid_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= head.data[idx_r];
      out_byte_valid <= head.byte_valid;
      out_error_code <= head.err;
      out_string_end <= head.str_end && fin;
      out_run_last   <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load)     valid_r <= 1'b1;
      else if (pop) valid_r <= 1'b0;
      if (load) idx_r <= fin ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule

// ===== design/jsu_checker.sv =====
// Port-level checks of the JSON string unescape decoder, bound to its top level.
// Depends on the defines header and on the top level's port list.
`include "json_string_unescape_decoder_top_defines.svh"

module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       pop,
  input logic       empty,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic [3:0] out_error_code,
  input logic       out_string_end,
  input logic       out_run_last
);

  // Nothing is offered right after reset.
  `JSU_ASSERT_RST(a_empty_after_reset, empty)

  // Results without a decoded byte carry a zero byte.
  `JSU_ASSERT_IMP(a_zero_byte, !empty && !out_byte_valid, out_byte == 8'd0)

  // An error result stands alone and carries no byte.
  `JSU_ASSERT_IMP(a_error_alone, !empty && out_error_code != jsu_pkg::ErrNone,
                  !out_byte_valid && out_run_last)

  // A held result stays in place until it is taken.
  `JSU_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(out_byte))

endmodule

bind json_string_unescape_decoder_top jsu_checker u_jsu_checker (.*);
